>>> hdl/wgfhl_pkg.sv
// ---------------------------------------------------------------------------
// wgfhl_pkg: shared types and constants of the group frame host learner
// Action and status codes, frame constants and the front-to-back command.
// ---------------------------------------------------------------------------
`default_nettype none
package wgfhl_pkg;
    localparam int TABLE_DEPTH = 64;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [2:0] ST_IGNORED = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_ADDED   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;
    localparam logic [2:0] ST_READ    = 3'd5;
    localparam logic [2:0] ST_BADIDX  = 3'd6;

    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [7:0]  SNAP_AA  = 8'hAA;
    localparam logic [7:0]  SNAP_UI  = 8'h03;
    localparam logic [10:0] LEN_MIN  = 11'd40;
    localparam logic [10:0] LEN_MAX  = 11'd1600;
    localparam logic [10:0] CCMP_LEN = 11'h08;
    localparam logic [10:0] SNAP_LEN = 11'd8;
    localparam logic [10:0] COUNT_SAT = 11'd2047;

    typedef enum logic [1:0] {
        CMD_IGNORE,
        CMD_LEARN,
        CMD_CLEAR,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [1:0]  how;
        logic [31:0] now;
        logic [5:0]  ridx;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_WRITE,
        BK_OUT
    } t_back_state;
endpackage
`default_nettype wire

>>> hdl/wgfhl_if.sv
// ---------------------------------------------------------------------------
// wgfhl_in_if / wgfhl_out_if: valid-ready channels of the learner
// One interface for input items, one for result items.
// ---------------------------------------------------------------------------
`default_nettype none
interface wgfhl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [5:0]  read_index;
    logic [31:0] time_ms;
    modport source (output valid, action, data_byte, last_byte, read_index, time_ms,
                    input ready);
    modport sink (input valid, action, data_byte, last_byte, read_index, time_ms,
                  output ready);
endinterface

interface wgfhl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  entry_index;
    logic [6:0]  device_count;
    logic [47:0] entry_mac;
    logic [31:0] entry_ip;
    logic [1:0]  entry_how;
    logic [31:0] entry_last_seen;
    modport source (output valid, status, entry_index, device_count, entry_mac, entry_ip,
                    entry_how, entry_last_seen, input ready);
    modport sink (input valid, status, entry_index, device_count, entry_mac, entry_ip,
                  entry_how, entry_last_seen, output ready);
endinterface
`default_nettype wire

>>> hdl/wgfhl_front.sv
// ---------------------------------------------------------------------------
// wgfhl_front: frame byte parser
// Tracks header and payload fields byte by byte and emits one command per
// last byte and per clear, read or unused item.
// ---------------------------------------------------------------------------
`default_nettype none
module wgfhl_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [47:0]     i_bssid,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [1:0]      i_action,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    input  wire logic [5:0]      i_ridx,
    input  wire logic [31:0]     i_time,
    output logic                 o_cmd_valid,
    input  wire logic            i_cmd_ready,
    output wgfhl_pkg::t_cmd      o_cmd
);
    import wgfhl_pkg::*;

    logic [10:0] r_cnt, n_cnt;
    logic [15:0] r_fc, n_fc;
    logic        r_hok, n_hok, r_sok, n_sok;
    logic [47:0] r_sa, n_sa, r_am, n_am;
    logic [15:0] r_ek, n_ek;
    logic [31:0] r_sip, n_sip;

    logic        w_acc, w_emit;
    logic [10:0] w_off, w_rel, w_len, w_n;
    logic        w_ok;
    logic [7:0]  w_want;
    logic [3:0]  w_bi;

    assign o_ready = i_cmd_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_emit  = w_acc && (i_action != ACT_BYTE || i_last);
    assign o_cmd_valid = w_emit;

    always_comb begin
        n_cnt = r_cnt; n_fc = r_fc; n_hok = r_hok; n_sok = r_sok;
        n_sa = r_sa; n_am = r_am; n_ek = r_ek; n_sip = r_sip;
        w_bi = 4'(11'd15 - r_cnt);
        w_want = 8'(i_bssid >> {w_bi[2:0], 3'b000});
        if (r_cnt == 11'd0) n_fc = {8'h00, i_byte};
        else if (r_cnt == 11'd1) n_fc = {i_byte, r_fc[7:0]};
        else if (r_cnt == 11'd4) begin
            if (!i_byte[0]) n_hok = 1'b0;
        end else if (r_cnt >= 11'd10 && r_cnt <= 11'd15) begin
            if (w_want != i_byte) n_hok = 1'b0;
        end else if (r_cnt >= 11'd16 && r_cnt <= 11'd21) begin
            n_sa = {r_sa[39:0], i_byte};
        end
        // offset uses frame control as updated by this byte
        w_off = 11'd24 + (n_fc[7] ? 11'd2 : 11'd0) + (n_fc[14] ? CCMP_LEN : 11'd0);
        w_rel = r_cnt - w_off;
        if (r_cnt >= 11'd2 && r_cnt >= w_off) begin
            if (w_rel <= 11'd1) begin
                if (i_byte != SNAP_AA) n_sok = 1'b0;
            end else if (w_rel == 11'd2) begin
                if (i_byte != SNAP_UI) n_sok = 1'b0;
            end else if (w_rel == 11'd6) n_ek = {i_byte, 8'h00};
            else if (w_rel == 11'd7) n_ek = {r_ek[15:8], i_byte};
            else if (w_rel >= 11'd16 && w_rel <= 11'd21) n_am = {r_am[39:0], i_byte};
            if (n_ek == ETH_ARP && w_rel >= 11'd22 && w_rel <= 11'd25)
                n_sip = {r_sip[23:0], i_byte};
            if (n_ek == ETH_IPV4 && w_rel >= 11'd20 && w_rel <= 11'd23)
                n_sip = {r_sip[23:0], i_byte};
        end
        if (r_cnt != COUNT_SAT) n_cnt = r_cnt + 11'd1;
    end

    always_comb begin
        w_len = n_cnt;
        w_n = w_len - w_off - SNAP_LEN;
        w_ok = n_hok && n_sok && w_len >= LEN_MIN && w_len <= LEN_MAX
            && n_fc[3:2] == 2'd2 && n_fc[9:8] == 2'd2 && w_len > w_off + SNAP_LEN;
        o_cmd = '0;
        o_cmd.now  = i_time;
        o_cmd.ridx = i_ridx;
        o_cmd.ip   = n_sip;
        unique case (i_action)
            ACT_BYTE: begin
                if (w_ok && n_ek == ETH_ARP && w_n >= 11'd28) begin
                    o_cmd.kind = CMD_LEARN; o_cmd.mac = n_am; o_cmd.how = 2'd1;
                end else if (w_ok && n_ek == ETH_IPV4 && w_n >= 11'd20) begin
                    o_cmd.kind = CMD_LEARN; o_cmd.mac = n_sa; o_cmd.how = 2'd2;
                end else o_cmd.kind = CMD_IGNORE;
            end
            ACT_CLEAR: o_cmd.kind = CMD_CLEAR;
            ACT_READ:  o_cmd.kind = CMD_READ;
            default:   o_cmd.kind = CMD_IGNORE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_acc && i_action == ACT_BYTE && i_last)) begin
            r_cnt <= '0; r_fc <= '0; r_hok <= 1'b1; r_sok <= 1'b1;
            r_sa <= '0; r_am <= '0; r_ek <= '0; r_sip <= '0;
        end else if (w_acc && i_action == ACT_BYTE) begin
            r_cnt <= n_cnt; r_fc <= n_fc; r_hok <= n_hok; r_sok <= n_sok;
            r_sa <= n_sa; r_am <= n_am; r_ek <= n_ek; r_sip <= n_sip;
        end
    end
endmodule
`default_nettype wire

>>> hdl/wgfhl_fifo.sv
// ---------------------------------------------------------------------------
// wgfhl_fifo: command queue
// Short register queue between parser and table engine.
// ---------------------------------------------------------------------------
`default_nettype none
module wgfhl_fifo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wgfhl_pkg::t_cmd  i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output wgfhl_pkg::t_cmd  o_data
);
    import wgfhl_pkg::*;
    t_cmd       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b00, w_push} - {2'b00, w_pop};
        end
    end
endmodule
`default_nettype wire

>>> hdl/wgfhl_back.sv
// ---------------------------------------------------------------------------
// wgfhl_back: device table engine
// Scans the table one slot a cycle, updates or appends, serves clear/read.
// ---------------------------------------------------------------------------
`default_nettype none
module wgfhl_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wgfhl_pkg::t_cmd  i_cmd,
    wgfhl_out_if.source      out
);
    import wgfhl_pkg::*;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [47:0] r_mac  [TABLE_DEPTH];
    logic [31:0] r_ip   [TABLE_DEPTH];
    logic [1:0]  r_how  [TABLE_DEPTH];
    logic [31:0] r_seen [TABLE_DEPTH];

    t_back_state r_st, n_st;
    t_cmd        r_cmd;
    logic [CW-1:0] r_dc, r_i;
    logic [47:0] r_rmac;
    logic [31:0] r_rip, r_rseen;
    logic [1:0]  r_rhow;
    logic        r_ov;
    logic [2:0]  r_status;
    logic [5:0]  r_idx;
    logic [47:0] r_omac;
    logic [31:0] r_oip, r_oseen;
    logic [1:0]  r_ohow;
    logic        r_rdv, r_hit;
    logic [31:0] w_nip;
    logic [1:0]  w_nhow;
    logic        w_skip, w_rd_ok, w_hold;
    logic [AW-1:0] w_raddr;

    assign o_ready = (r_st == BK_IDLE) && !r_ov;
    assign w_nip  = (r_cmd.ip != 32'd0) ? r_cmd.ip : r_rip;
    assign w_nhow = r_hit ? (r_rhow | r_cmd.how) : r_cmd.how;
    // multicast or all-zero MAC is never learned
    assign w_skip = (i_cmd.kind == CMD_LEARN) && (i_cmd.mac[40] || i_cmd.mac == 48'd0);
    assign w_rd_ok = CW'(i_cmd.ridx) < r_dc;
    // hold the matching slot's data for the write cycle
    assign w_hold = (r_st == BK_SCAN) && r_rdv && (r_rmac == r_cmd.mac);
    assign w_raddr = (r_st == BK_IDLE) ? AW'(i_cmd.ridx) : r_i[AW-1:0];

    // registered table read: read index while idle, scan pointer otherwise
    always_ff @(posedge i_clk) begin
        if (!w_hold) begin
            r_rmac  <= r_mac[w_raddr];
            r_rip   <= r_ip[w_raddr];
            r_rhow  <= r_how[w_raddr];
            r_rseen <= r_seen[w_raddr];
        end
        if (r_st == BK_WRITE) begin
            r_ip[r_i[AW-1:0]]   <= r_hit ? w_nip : r_cmd.ip;
            r_how[r_i[AW-1:0]]  <= w_nhow;
            r_seen[r_i[AW-1:0]] <= r_cmd.now;
            if (!r_hit) r_mac[r_i[AW-1:0]] <= r_cmd.mac;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BK_IDLE: if (i_valid && o_ready) begin
                if (i_cmd.kind == CMD_LEARN && !w_skip) n_st = BK_SCAN;
                else if (i_cmd.kind == CMD_READ && w_rd_ok) n_st = BK_OUT;
            end
            BK_SCAN:  if (w_hold) n_st = BK_WRITE;
                      else if (r_i >= r_dc) n_st = (r_dc >= CW'(TABLE_DEPTH)) ? BK_OUT : BK_WRITE;
            BK_WRITE: n_st = BK_IDLE;
            BK_OUT:   n_st = BK_IDLE;
            default:  n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE; r_dc <= '0; r_ov <= 1'b0; r_i <= '0; r_rdv <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_st <= n_st;
            if (out.valid && out.ready) r_ov <= 1'b0;
            priority case (r_st)
                BK_IDLE: if (i_valid && o_ready) begin
                    r_cmd <= i_cmd;
                    r_i <= '0; r_rdv <= 1'b0; r_hit <= 1'b0;
                    unique case (i_cmd.kind)
                        CMD_LEARN: if (w_skip) begin
                            r_ov <= 1'b1; r_status <= ST_IGNORED; r_idx <= '0;
                            r_omac <= '0; r_oip <= '0; r_ohow <= '0; r_oseen <= '0;
                        end
                        CMD_CLEAR: begin
                            r_dc <= '0; r_ov <= 1'b1; r_status <= ST_CLEARED;
                            r_idx <= '0; r_omac <= '0; r_oip <= '0; r_ohow <= '0; r_oseen <= '0;
                        end
                        CMD_READ: begin
                            r_ov <= !w_rd_ok; r_idx <= i_cmd.ridx;
                            r_omac <= '0; r_oip <= '0; r_ohow <= '0; r_oseen <= '0;
                            r_status <= ST_BADIDX;
                        end
                        default: begin
                            r_ov <= 1'b1; r_status <= ST_IGNORED; r_idx <= '0;
                            r_omac <= '0; r_oip <= '0; r_ohow <= '0; r_oseen <= '0;
                        end
                    endcase
                end
                BK_SCAN: begin
                    r_rdv <= r_i < r_dc;
                    if (w_hold) begin
                        r_i <= r_i - CW'(1); r_hit <= 1'b1;
                    end else if (r_i >= r_dc) r_i <= r_dc;
                    else r_i <= r_i + CW'(1);
                end
                BK_WRITE: begin
                    r_ov <= 1'b1;
                    r_idx <= 6'(r_i);
                    r_omac <= r_cmd.mac;
                    r_oseen <= r_cmd.now;
                    r_ohow <= w_nhow;
                    r_oip <= r_hit ? w_nip : r_cmd.ip;
                    r_status <= r_hit ? ST_UPDATED : ST_ADDED;
                    if (!r_hit) r_dc <= r_dc + CW'(1);
                end
                BK_OUT: begin
                    r_ov <= 1'b1;
                    if (r_cmd.kind == CMD_READ) begin
                        r_status <= ST_READ; r_omac <= r_rmac; r_oip <= r_rip;
                        r_ohow <= r_rhow; r_oseen <= r_rseen;
                    end else begin
                        r_status <= ST_FULL; r_idx <= '0;
                        r_omac <= '0; r_oip <= '0; r_ohow <= '0; r_oseen <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out.valid = r_ov;
    assign out.status = r_status;
    assign out.entry_index = r_idx;
    assign out.device_count = 7'(r_dc);
    assign out.entry_mac = r_omac;
    assign out.entry_ip = r_oip;
    assign out.entry_how = r_ohow;
    assign out.entry_last_seen = r_oseen;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dc <= CW'(TABLE_DEPTH)) else $error("device count overflow");
    a_busy_noready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != BK_IDLE |-> !o_ready) else $error("ready while busy");
    a_write_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == BK_WRITE |=> r_ov) else $error("write without result");
`endif
endmodule
`default_nettype wire

>>> hdl/wlan_group_frame_host_learner.sv
// ---------------------------------------------------------------------------
// wlan_group_frame_host_learner: group frame host learner top level
// Parser front, command queue and device table back end.
// ---------------------------------------------------------------------------
// Frame bytes are taken one per cycle while the command queue has room. A learn
// command scans the table one slot a cycle in the table engine; a four-deep
// command queue lets the next frame's bytes be parsed meanwhile. Clear and read
// do not scan the table.
`default_nettype none
module wlan_group_frame_host_learner (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [47:0] i_cfg_wdata,
    wgfhl_in_if.sink         in_ch,
    wgfhl_out_if.source      out_ch
);
    import wgfhl_pkg::*;
    logic [47:0] r_bssid;
    logic        w_cv, w_cr, w_bv, w_br;
    t_cmd        w_cmd, w_bcmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bssid <= '0;
        else if (i_cfg_we) r_bssid <= i_cfg_wdata;
    end

    wgfhl_front u_front (
        .i_clk, .i_rst_n, .i_bssid(r_bssid),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_action(in_ch.action),
        .i_byte(in_ch.data_byte), .i_last(in_ch.last_byte), .i_ridx(in_ch.read_index),
        .i_time(in_ch.time_ms), .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );
    wgfhl_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(w_cv), .o_ready(w_cr), .i_data(w_cmd),
        .o_valid(w_bv), .i_ready(w_br), .o_data(w_bcmd)
    );
    wgfhl_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_bv), .o_ready(w_br), .i_cmd(w_bcmd), .out(out_ch)
    );
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench of the group frame host learner
// Drives frame bytes, clear and read commands through the input channel,
// predicts every result from a local model of the parser and device table,
// and checks each result transaction field by field under random stalls.
// ---------------------------------------------------------------------------
module tb_top;
    import wgfhl_pkg::*;

    localparam int DEPTH     = 64;
    localparam int CYC_LIMIT = 600000;
    localparam int DRAIN_GAP = 80;

    typedef struct {
        logic [2:0]  status;
        logic [5:0]  idx;
        logic [6:0]  count;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [1:0]  how;
        logic [31:0] seen;
    } t_host_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [47:0] i_cfg_wdata;

    wgfhl_in_if  in_ch ();
    wgfhl_out_if out_ch ();

    wlan_group_frame_host_learner dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // local copy of parser and table state
    logic [47:0] m_bssid;
    logic [10:0] m_pos;
    logic [15:0] m_fc;
    logic        m_hdr_ok;
    logic [47:0] m_a3;
    logic [15:0] m_ek;
    logic        m_snap_ok;
    logic [47:0] m_arp_mac;
    logic [31:0] m_sip;
    logic [47:0] m_mac  [DEPTH];
    logic [31:0] m_ip   [DEPTH];
    logic [1:0]  m_how  [DEPTH];
    logic [31:0] m_seen [DEPTH];
    logic [6:0]  m_count;

    t_host_result host_results_q[$];
    int n_fail, n_checked, n_items, n_added, n_updated, n_full;
    int cycles;
    int hold_cnt;
    bit no_idle;
    logic [47:0] mac_pool[12];

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- prediction ----------------
    function automatic t_host_result mk(logic [2:0] st, logic [5:0] idx, logic [47:0] mac,
                                        logic [31:0] ip, logic [1:0] how, logic [31:0] seen);
        t_host_result r;
        r.status = st; r.idx = idx; r.count = m_count; r.mac = mac;
        r.ip = ip; r.how = how; r.seen = seen;
        return r;
    endfunction

    function automatic int hdr_len();
        int off;
        off = 24;
        if (m_fc[7]) off += 2;
        if (m_fc[14]) off += 8;
        return off;
    endfunction

    task automatic frame_reset();
        m_pos = '0; m_fc = '0; m_hdr_ok = 1'b1; m_a3 = '0; m_ek = '0;
        m_snap_ok = 1'b1; m_arp_mac = '0; m_sip = '0;
    endtask

    task automatic parse_byte(logic [7:0] b);
        int p, rel;
        p = m_pos;
        if (p == 0) m_fc = {8'h00, b};
        else if (p == 1) m_fc[15:8] = b;
        else if (p == 4) begin
            if (!b[0]) m_hdr_ok = 1'b0;
        end else if (p >= 10 && p <= 15) begin
            if (m_bssid[8*(15-p) +: 8] != b) m_hdr_ok = 1'b0;
        end else if (p >= 16 && p <= 21) m_a3 = {m_a3[39:0], b};
        if (p < 2 || p < hdr_len()) return;
        rel = p - hdr_len();
        if (rel <= 1) begin
            if (b != SNAP_AA) m_snap_ok = 1'b0;
        end else if (rel == 2) begin
            if (b != SNAP_UI) m_snap_ok = 1'b0;
        end else if (rel == 6) m_ek = {b, 8'h00};
        else if (rel == 7) m_ek[7:0] = b;
        else if (rel >= 16 && rel <= 21) m_arp_mac = {m_arp_mac[39:0], b};
        if (m_ek == ETH_ARP && rel >= 22 && rel <= 25) m_sip = {m_sip[23:0], b};
        if (m_ek == ETH_IPV4 && rel >= 20 && rel <= 23) m_sip = {m_sip[23:0], b};
    endtask

    function automatic t_host_result learn_host(logic [47:0] mac, logic [31:0] ip,
                                                logic [1:0] how, logic [31:0] now);
        int s;
        if (mac[40] || mac == '0) return mk(ST_IGNORED, 0, 0, 0, 0, 0);
        for (int i = 0; i < m_count; i++) begin
            if (m_mac[i] == mac) begin
                if (ip != 0) m_ip[i] = ip;
                m_how[i] = m_how[i] | how;
                m_seen[i] = now;
                n_updated++;
                return mk(ST_UPDATED, i, m_mac[i], m_ip[i], m_how[i], now);
            end
        end
        if (m_count >= DEPTH) begin
            n_full++;
            return mk(ST_FULL, 0, 0, 0, 0, 0);
        end
        s = m_count;
        m_count++;
        m_mac[s] = mac; m_ip[s] = ip; m_how[s] = how; m_seen[s] = now;
        n_added++;
        return mk(ST_ADDED, s, mac, ip, how, now);
    endfunction

    task automatic predict_item(logic [1:0] act, logic [7:0] b, logic last,
                                logic [5:0] ridx, logic [31:0] now);
        int len, off, n;
        bit ok;
        if (act == ACT_BYTE) begin
            parse_byte(b);
            if (m_pos < COUNT_SAT) m_pos++;
            if (!last) return;
            len = m_pos; off = hdr_len(); n = len - off - 8;
            ok = m_hdr_ok && m_snap_ok && len >= LEN_MIN && len <= LEN_MAX &&
                 m_fc[3:2] == 2'd2 && m_fc[9:8] == 2'd2 && len > off + 8;
            if (ok && m_ek == ETH_ARP && n >= 28)
                host_results_q.push_back(learn_host(m_arp_mac, m_sip, 2'b01, now));
            else if (ok && m_ek == ETH_IPV4 && n >= 20)
                host_results_q.push_back(learn_host(m_a3, m_sip, 2'b10, now));
            else
                host_results_q.push_back(mk(ST_IGNORED, 0, 0, 0, 0, 0));
            frame_reset();
        end else if (act == ACT_CLEAR) begin
            m_count = '0;
            host_results_q.push_back(mk(ST_CLEARED, 0, 0, 0, 0, 0));
        end else if (act == ACT_READ) begin
            if (ridx < m_count)
                host_results_q.push_back(mk(ST_READ, ridx, m_mac[ridx], m_ip[ridx],
                                            m_how[ridx], m_seen[ridx]));
            else
                host_results_q.push_back(mk(ST_BADIDX, ridx, 0, 0, 0, 0));
        end else begin
            host_results_q.push_back(mk(ST_IGNORED, 0, 0, 0, 0, 0));
        end
    endtask

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        t_host_result e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (host_results_q.size() == 0) begin
                $error("result with no expectation, status %0d", out_ch.status);
                n_fail++;
            end else begin
                e = host_results_q.pop_front();
                n_checked++;
                if (out_ch.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, out_ch.status); n_fail++;
                end
                if (out_ch.entry_index !== e.idx) begin
                    $error("entry_index exp %0d got %0d", e.idx, out_ch.entry_index); n_fail++;
                end
                if (out_ch.device_count !== e.count) begin
                    $error("device_count exp %0d got %0d", e.count, out_ch.device_count);
                    n_fail++;
                end
                if (out_ch.entry_mac !== e.mac) begin
                    $error("entry_mac exp %h got %h", e.mac, out_ch.entry_mac); n_fail++;
                end
                if (out_ch.entry_ip !== e.ip) begin
                    $error("entry_ip exp %h got %h", e.ip, out_ch.entry_ip); n_fail++;
                end
                if (out_ch.entry_how !== e.how) begin
                    $error("entry_how exp %0d got %0d", e.how, out_ch.entry_how); n_fail++;
                end
                if (out_ch.entry_last_seen !== e.seen) begin
                    $error("entry_last_seen exp %h got %h", e.seen, out_ch.entry_last_seen);
                    n_fail++;
                end
            end
        end
    end

    // receiver: random stalls, long hold-off when hold_cnt is loaded
    always @(negedge i_clk) begin
        int r;
        if (!i_rst_n) out_ch.ready = 1'b0;
        else if (hold_cnt > 0) begin
            out_ch.ready = 1'b0;
            hold_cnt--;
        end else if (no_idle) out_ch.ready = 1'b1;
        else begin
            r = $urandom_range(0, 99);
            out_ch.ready = (r < 70);
            if (r == 99) hold_cnt = $urandom_range(10, 40);
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_item(logic [1:0] act, logic [7:0] b, logic last, logic [5:0] ridx);
        int g;
        logic [31:0] now;
        g = pick_gap();
        if (g > 0) begin
            in_ch.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        now = $urandom;
        in_ch.action = act; in_ch.data_byte = b; in_ch.last_byte = last;
        in_ch.read_index = ridx; in_ch.time_ms = now; in_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(act, b, last, ridx, now);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (host_results_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic write_bssid(logic [47:0] v);
        drain();
        i_cfg_wdata = v; i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        m_bssid = v;
    endtask

    // kind 0 ARP, 1 IPv4, 2 other EtherType
    task automatic build_frame(output logic [7:0] f[$], input int kind, input logic [47:0] mac,
                               input logic [31:0] ip, input int pad);
        logic [47:0] a3;
        logic [15:0] ek;
        bit qos, prot;
        qos = $urandom_range(0, 1); prot = $urandom_range(0, 1);
        a3 = (kind == 1) ? mac : {$urandom, $urandom};
        ek = (kind == 0) ? ETH_ARP : (kind == 1) ? ETH_IPV4 : 16'($urandom);
        f = {};
        f.push_back(8'h08 | (qos ? 8'h80 : 8'h00));
        f.push_back(8'h02 | (prot ? 8'h40 : 8'h00) | (8'($urandom) & 8'hB0));
        f.push_back($urandom); f.push_back($urandom);
        f.push_back(8'($urandom) | 8'h01);
        repeat (5) f.push_back($urandom);
        for (int i = 5; i >= 0; i--) f.push_back(m_bssid[8*i +: 8]);
        for (int i = 5; i >= 0; i--) f.push_back(a3[8*i +: 8]);
        f.push_back($urandom); f.push_back($urandom);
        if (qos) repeat (2) f.push_back($urandom);
        if (prot) repeat (8) f.push_back($urandom);
        f.push_back(SNAP_AA); f.push_back(SNAP_AA); f.push_back(SNAP_UI);
        repeat (3) f.push_back(8'h00);
        f.push_back(ek[15:8]); f.push_back(ek[7:0]);
        if (kind == 0) begin
            repeat (8) f.push_back($urandom);
            for (int i = 5; i >= 0; i--) f.push_back(mac[8*i +: 8]);
            for (int i = 3; i >= 0; i--) f.push_back(ip[8*i +: 8]);
            repeat (10) f.push_back($urandom);
        end else begin
            repeat (12) f.push_back($urandom);
            for (int i = 3; i >= 0; i--) f.push_back(ip[8*i +: 8]);
            repeat (4) f.push_back($urandom);
        end
        repeat (pad) f.push_back($urandom);
    endtask

    // send a frame; mix > 0 puts clear/read/unused items between bytes now and then
    task automatic send_frame(logic [7:0] f[$], int mix);
        int r;
        for (int i = 0; i < f.size(); i++) begin
            if (mix > 0 && $urandom_range(0, 999) < mix) begin
                r = $urandom_range(0, 9);
                if (r < 7) send_item(ACT_READ, $urandom, $urandom, $urandom);
                else if (r < 9) send_item(ACT_NONE, $urandom, $urandom, $urandom);
                else send_item(ACT_CLEAR, $urandom, $urandom, $urandom);
            end
            send_item(ACT_BYTE, f[i], i == f.size() - 1, $urandom);
        end
    endtask

    task automatic learn_frame(int kind, logic [47:0] mac, logic [31:0] ip);
        logic [7:0] f[$];
        build_frame(f, kind, mac, ip, $urandom_range(0, 6));
        send_frame(f, 0);
    endtask

    function automatic logic [47:0] rand_unicast();
        logic [47:0] m;
        m = {$urandom, $urandom};
        m[40] = 1'b0;
        return m;
    endfunction

    // ---------------- tests ----------------
    task automatic test_empty_table();
        send_item(ACT_READ, 8'h00, 1'b0, 6'd0);
        send_item(ACT_READ, 8'hFF, 1'b1, 6'd63);
        send_item(ACT_NONE, 8'h55, 1'b1, 6'd21);
        send_item(ACT_CLEAR, 8'hAA, 1'b0, 6'd42);
        send_item(ACT_BYTE, 8'hFF, 1'b1, 6'd0);  // one-byte frame
    endtask

    task automatic test_basic_learning();
        logic [47:0] m;
        m = 48'h0211_2233_4455;
        learn_frame(0, m, 32'hC0A8_0001);
        learn_frame(1, m, 32'h0);                 // update, keep IP
        learn_frame(1, 48'h0266_7788_99AA, 32'hFFFF_FFFF);
        learn_frame(0, 48'h0100_5E00_0001, 32'h0A00_0001);  // multicast sender
        learn_frame(1, 48'h0, 32'h0A00_0002);               // all-zero MAC
        send_item(ACT_READ, 8'h00, 1'b0, 6'd0);
        send_item(ACT_READ, 8'h00, 1'b0, 6'd1);
        send_item(ACT_READ, 8'h00, 1'b0, 6'd2);
    endtask

    task automatic test_length_limits();
        logic [7:0] f[$];
        build_frame(f, 0, rand_unicast(), $urandom, 0);
        f = f[0:f.size()-3];                             // ARP body too short
        send_frame(f, 0);
        build_frame(f, 1, rand_unicast(), $urandom, 0);
        f = f[0:38];                                     // one byte under the minimum
        send_frame(f, 0);
    endtask

    task automatic test_midframe_commands();
        logic [7:0] f[$];
        build_frame(f, 0, mac_pool[0], $urandom, 3);
        send_frame(f, 200);
    endtask

    task automatic test_random_traffic(int n_frames);
        logic [7:0] f[$];
        logic [47:0] m;
        int r, k;
        for (int t = 0; t < n_frames; t++) begin
            r = $urandom_range(0, 99);
            m = ($urandom_range(0, 3) != 0) ? mac_pool[$urandom_range(0, 11)] : rand_unicast();
            if ($urandom_range(0, 29) == 0) m[40] = 1'b1;
            build_frame(f, $urandom_range(0, 9) < 9 ? $urandom_range(0, 1) : 2, m,
                        $urandom_range(0, 3) == 0 ? 32'h0 : $urandom, $urandom_range(0, 12));
            if (r < 70) send_frame(f, 15);
            else if (r < 85) begin
                k = $urandom_range(0, 40);     // flip one bit of one of the first 41 frame bytes
                f[k] = f[k] ^ (8'h1 << $urandom_range(0, 7));
                send_frame(f, 15);
            end else if (r < 93) begin
                f = {};
                repeat ($urandom_range(1, 60)) f.push_back($urandom);
                send_frame(f, 15);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item($urandom_range(1, 3), $urandom, $urandom, $urandom);
            end
            if ($urandom_range(0, 19) == 0) drain();
        end
    endtask

    // long receiver hold-off while reads keep coming, so the queue fills up
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_cnt = 200;
        repeat (12) send_item(ACT_READ, $urandom, $urandom, $urandom);
        test_random_traffic(2);
        no_idle = 1'b0;
        drain();
    endtask

    initial begin
        n_fail = 0; n_checked = 0; n_items = 0; cycles = 0; hold_cnt = 0; no_idle = 0;
        n_added = 0; n_updated = 0; n_full = 0;
        in_ch.valid = 1'b0; in_ch.action = ACT_BYTE; in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0; in_ch.read_index = '0; in_ch.time_ms = '0;
        i_cfg_we = 1'b0; i_cfg_wdata = '0;
        out_ch.ready = 1'b0;
        m_bssid = '0; m_count = '0;
        frame_reset();
        for (int i = 0; i < 12; i++) mac_pool[i] = rand_unicast();
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_basic_learning();
        write_bssid(48'hFFFF_FFFF_FFFF);
        test_length_limits();
        test_midframe_commands();
        write_bssid(rand_unicast());
        test_backpressure();
        test_random_traffic(1);

        drain();
        $display("items sent: %0d, results checked: %0d", n_items, n_checked);
        $display("hosts added %0d, updated %0d, table full %0d", n_added, n_updated, n_full);
        if (n_fail == 0 && host_results_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/wgfhl_pkg.sv
hdl/wgfhl_if.sv
hdl/wgfhl_front.sv
hdl/wgfhl_fifo.sv
hdl/wgfhl_back.sv
hdl/wlan_group_frame_host_learner.sv
tb/sv/tb_top.sv
